>>> design/pfd_pkg.sv
`timescale 1ns / 1ps

package pfd_pkg;

    // Default datapath format
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Derivative filter weight: unsigned Q1.16, one is 2^16
    localparam int ALPHA_BITS = 16;
    localparam int ALPHA_W    = 17;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h1_0000;

    // Gain terms saturate at +/-2^60; sums are carried at 64 bits
    localparam int TERM_W = 62;
    localparam int SUM_W  = 64;
    localparam logic signed [SUM_W-1:0] TERM_LIM = 64'sh1000_0000_0000_0000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP         = 3'd0,
        REG_KI_DT      = 3'd1,
        REG_KD_OVER_DT = 3'd2,
        REG_ALPHA      = 3'd3,
        REG_INT_LIMIT  = 3'd4,
        REG_OUT_LIMIT  = 3'd5,
        REG_FF_GAIN    = 3'd6,
        REG_AW_MODE    = 3'd7
    } reg_idx_t;

    // Multiplier operations, also used to tag the writeback of a product
    typedef enum logic [2:0] {
        OP_NONE,
        OP_P,
        OP_FF,
        OP_INC,
        OP_DOLD,
        OP_FILT,
        OP_D
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_FF,
        ST_MUL_INC,
        ST_MUL_DOLD,
        ST_MUL_FILT,
        ST_UPDATE,
        ST_MUL_D,
        ST_D_WB,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        op_t  mul_op;
        op_t  wb_op;
        logic load_in;
        logic do_update;
        logic do_output;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

>>> design/pfd_ctrl.sv
`timescale 1ns / 1ps

module pfd_ctrl
    import pfd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   s_tvalid,
    output logic   s_tready,
    output cmd_t   cmd,
    input  sts_t   sts
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: fixed multiply sequence, hold at output until the slot frees
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_MUL_P;
                end
            end
            ST_MUL_P:    state_next = ST_MUL_FF;
            ST_MUL_FF:   state_next = ST_MUL_INC;
            ST_MUL_INC:  state_next = ST_MUL_DOLD;
            ST_MUL_DOLD: state_next = ST_MUL_FILT;
            ST_MUL_FILT: state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_MUL_D;
            ST_MUL_D:    state_next = ST_D_WB;
            ST_D_WB:     state_next = ST_OUTPUT;
            ST_OUTPUT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Commands: each product is written back in the state after its multiply
    always_comb
    begin
        s_tready      = 1'b0;
        cmd.mul_op    = OP_NONE;
        cmd.wb_op     = OP_NONE;
        cmd.load_in   = 1'b0;
        cmd.do_update = 1'b0;
        cmd.do_output = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_MUL_P:
            begin
                cmd.mul_op = OP_P;
            end
            ST_MUL_FF:
            begin
                cmd.mul_op = OP_FF;
                cmd.wb_op  = OP_P;
            end
            ST_MUL_INC:
            begin
                cmd.mul_op = OP_INC;
                cmd.wb_op  = OP_FF;
            end
            ST_MUL_DOLD:
            begin
                cmd.mul_op = OP_DOLD;
                cmd.wb_op  = OP_INC;
            end
            ST_MUL_FILT:
            begin
                cmd.mul_op = OP_FILT;
                cmd.wb_op  = OP_DOLD;
            end
            ST_UPDATE:
            begin
                cmd.wb_op     = OP_FILT;
                cmd.do_update = 1'b1;
            end
            ST_MUL_D:
            begin
                cmd.mul_op = OP_D;
            end
            ST_D_WB:
            begin
                cmd.wb_op = OP_D;
            end
            ST_OUTPUT:
            begin
                cmd.do_output = sts.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> design/pfd_datapath.sv
`timescale 1ns / 1ps

module pfd_datapath
    import pfd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int CFG_W = (DATA_WIDTH > ALPHA_W) ? DATA_WIDTH : ALPHA_W,
    localparam int S_W   = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int M_W   = ((DATA_WIDTH + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic [S_W-1:0]       s_tdata,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_W-1:0]       m_tdata,
    output logic                 m_tuser
);

    localparam int W     = DATA_WIDTH;
    localparam int FD_W  = W + 1;
    localparam int MA_W  = W + 2;
    localparam int MB_W  = (W + 1 > ALPHA_W + 1) ? W + 1 : ALPHA_W + 1;
    localparam int PW    = MA_W + MB_W;
    localparam int EXT_W = (PW > SUM_W) ? PW : SUM_W;
    localparam logic signed [EXT_W-1:0] LIM_E = EXT_W'(TERM_LIM);

    // Configuration registers
    logic signed [W-1:0]   kp_reg;
    logic signed [W-1:0]   ki_reg;
    logic signed [W-1:0]   kd_reg;
    logic signed [W-1:0]   ffg_reg;
    logic [ALPHA_W-1:0]    alpha_reg;
    logic [W-2:0]          ilim_reg;
    logic [W-2:0]          olim_reg;
    logic                  aw_mode_reg;

    // Controller state carried across samples
    logic signed [W-1:0]    prev_reg;
    logic signed [W-1:0]    acc_reg;
    logic signed [FD_W-1:0] fd_reg;

    // Per-sample working registers
    logic signed [W-1:0]      err_reg;
    logic signed [W-1:0]      ffin_reg;
    logic signed [MA_W-1:0]   dd_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [TERM_W-1:0] p_reg;
    logic signed [TERM_W-1:0] ff_reg;
    logic signed [TERM_W-1:0] inc_reg;
    logic signed [TERM_W-1:0] dold_reg;
    logic signed [TERM_W-1:0] d_reg;

    // Output slot
    logic signed [W-1:0] drive_reg;
    logic                sat_reg;
    logic                out_valid_reg;

    logic signed [W-1:0]      err_in;
    logic signed [W-1:0]      ffin_in;
    logic [ALPHA_W-1:0]       alpha_eff;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PW-1:0]     prod_next;
    logic signed [EXT_W-1:0]  prod_ext;
    logic signed [EXT_W-1:0]  prod_sh;
    logic signed [TERM_W-1:0] term;
    logic signed [SUM_W-1:0]  fd_sum;
    logic                     fd_fits;
    logic signed [FD_W-1:0]   fd_new;
    logic signed [SUM_W-1:0]  olim_s;
    logic signed [SUM_W-1:0]  ilim_s;
    logic signed [SUM_W-1:0]  acc_sum;
    logic signed [SUM_W-1:0]  tent;
    logic signed [SUM_W-1:0]  acc_clamp;
    logic                     err_pos;
    logic                     err_neg;
    logic                     int_update;
    logic signed [SUM_W-1:0]  iterm;
    logic signed [SUM_W-1:0]  sum;
    logic signed [W-1:0]      drive_next;
    logic                     sat_next;

    assign err_in  = s_tdata[W-1:0];
    assign ffin_in = s_tdata[2*W-1:W];
    assign olim_s  = SUM_W'(olim_reg);
    assign ilim_s  = SUM_W'(ilim_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg      <= '0;
            ki_reg      <= '0;
            kd_reg      <= '0;
            ffg_reg     <= '0;
            alpha_reg   <= ALPHA_ONE;
            ilim_reg    <= '1;
            olim_reg    <= '1;
            aw_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KP:         kp_reg      <= cfg_wdata[W-1:0];
                REG_KI_DT:      ki_reg      <= cfg_wdata[W-1:0];
                REG_KD_OVER_DT: kd_reg      <= cfg_wdata[W-1:0];
                REG_ALPHA:      alpha_reg   <= cfg_wdata[ALPHA_W-1:0];
                REG_INT_LIMIT:  ilim_reg    <= cfg_wdata[W-2:0];
                REG_OUT_LIMIT:  olim_reg    <= cfg_wdata[W-2:0];
                REG_FF_GAIN:    ffg_reg     <= cfg_wdata[W-1:0];
                REG_AW_MODE:    aw_mode_reg <= cfg_wdata[0];
                default:        aw_mode_reg <= aw_mode_reg;
            endcase
        end
    end

    // Limit alpha to one
    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;

    // Select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_op)
            OP_P:
            begin
                mul_a = MA_W'(err_reg);
                mul_b = MB_W'(kp_reg);
            end
            OP_FF:
            begin
                mul_a = MA_W'(ffin_reg);
                mul_b = MB_W'(ffg_reg);
            end
            OP_INC:
            begin
                mul_a = MA_W'(err_reg);
                mul_b = MB_W'(ki_reg);
            end
            OP_DOLD, OP_D:
            begin
                mul_a = MA_W'(fd_reg);
                mul_b = MB_W'(kd_reg);
            end
            OP_FILT:
            begin
                mul_a = dd_reg;
                mul_b = MB_W'(alpha_eff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Shift the registered product down (floor) and saturate to +/-2^60
    assign prod_ext = EXT_W'(prod_reg);
    assign prod_sh  = (cmd.wb_op == OP_FILT) ? (prod_ext >>> ALPHA_BITS)
                                             : (prod_ext >>> FRAC_BITS);
    always_comb
    begin
        if (prod_sh > LIM_E)
        begin
            term = TERM_W'(LIM_E);
        end
        else if (prod_sh < -LIM_E)
        begin
            term = TERM_W'(-LIM_E);
        end
        else
        begin
            term = prod_sh[TERM_W-1:0];
        end
    end

    // Filter step, saturated to DATA_WIDTH+1 bits
    assign fd_sum  = SUM_W'(fd_reg) + SUM_W'(term);
    assign fd_fits = (fd_sum[SUM_W-1:FD_W-1] == '0) || (fd_sum[SUM_W-1:FD_W-1] == '1);
    assign fd_new  = fd_fits ? fd_sum[FD_W-1:0]
                   : (fd_sum[SUM_W-1] ? {1'b1, {W{1'b0}}} : {1'b0, {W{1'b1}}});

    // Integral update with optional conditional integration
    assign acc_sum = SUM_W'(acc_reg) + SUM_W'(inc_reg);
    assign tent    = SUM_W'(p_reg) + acc_sum + SUM_W'(dold_reg) + SUM_W'(ff_reg);
    assign err_pos = !err_reg[W-1] && (err_reg != '0);
    assign err_neg = err_reg[W-1];
    assign int_update = !aw_mode_reg
                     || !(((tent >= olim_s) && err_pos) || ((tent <= -olim_s) && err_neg));

    always_comb
    begin
        if (acc_sum > ilim_s)
        begin
            acc_clamp = ilim_s;
        end
        else if (acc_sum < -ilim_s)
        begin
            acc_clamp = -ilim_s;
        end
        else
        begin
            acc_clamp = acc_sum;
        end
    end

    // Final sum and output clamp
    assign iterm = (ki_reg != '0) ? SUM_W'(acc_reg) : '0;
    assign sum   = SUM_W'(p_reg) + iterm + SUM_W'(d_reg) + SUM_W'(ff_reg);

    always_comb
    begin
        if (sum > olim_s)
        begin
            drive_next = W'(olim_s);
            sat_next   = 1'b1;
        end
        else if (sum < -olim_s)
        begin
            drive_next = W'(-olim_s);
            sat_next   = 1'b1;
        end
        else
        begin
            drive_next = sum[W-1:0];
            sat_next   = 1'b0;
        end
    end

    // Capture the sample, run the multiplier and write back terms
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            err_reg  <= err_in;
            ffin_reg <= ffin_in;
            dd_reg   <= MA_W'(err_in) - MA_W'(prev_reg) - MA_W'(fd_reg);
        end
        if (cmd.mul_op != OP_NONE)
        begin
            prod_reg <= prod_next;
        end
        unique case (cmd.wb_op)
            OP_P:    p_reg    <= term;
            OP_FF:   ff_reg   <= term;
            OP_INC:  inc_reg  <= term;
            OP_DOLD: dold_reg <= term;
            OP_D:    d_reg    <= term;
            default: d_reg    <= d_reg;
        endcase
        if (cmd.do_output)
        begin
            drive_reg <= drive_next;
            sat_reg   <= sat_next;
        end
    end

    // Advance the controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            acc_reg  <= '0;
            fd_reg   <= '0;
        end
        else
        begin
            if ((cmd.wb_op == OP_FILT) && (kd_reg != '0))
            begin
                fd_reg <= fd_new;
            end
            if (cmd.do_update)
            begin
                prev_reg <= err_reg;
                if ((ki_reg != '0) && int_update)
                begin
                    acc_reg <= acc_clamp[W-1:0];
                end
            end
        end
    end

    // Output slot valid: set when a result is written, drop when the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.do_output)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = M_W'($unsigned(drive_reg));
    assign m_tuser      = sat_reg;

    // A new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_output |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before transaction");

    // A flagged result sits exactly at one of the limits
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            ((drive_reg == W'(olim_s)) || (drive_reg == W'(-olim_s))))
        else $error("saturated result not at limit");

    // Drive stays within the output limit
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((SUM_W'(drive_reg) <= olim_s) && (SUM_W'(drive_reg) >= -olim_s)))
        else $error("drive beyond output limit");

    // Filter state frozen while the derivative gain is zero
    a_fd_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.wb_op == OP_FILT) && (kd_reg == '0)) |=> $stable(fd_reg))
        else $error("filter state moved with zero derivative gain");

endmodule

>>> design/pid_filtered_derivative_antiwindup_core.sv
`timescale 1ns / 1ps
// Samples are handled one at a time: a new sample is accepted only once the result of
// the last one has entered the output slot, as the single shared multiplier forms six
// products in sequence; a waiting result stalls only the final step.
// Reset (rst_n, asynchronous, active low) clears the integral, filter and
// previous-error state and loads the register defaults; no clearing pass.

module pid_filtered_derivative_antiwindup_core
    import pfd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int CFG_W = (DATA_WIDTH > ALPHA_W) ? DATA_WIDTH : ALPHA_W,
    localparam int S_W   = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int M_W   = ((DATA_WIDTH + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_W-1:0]       s_tdata,   // error, feedforward
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_W-1:0]       m_tdata,   // drive
    output logic                 m_tuser    // saturated
);

    cmd_t cmd;
    sts_t sts;

    pfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    pfd_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> bench/drive_checker.sv
`timescale 1ns / 1ps

module drive_checker
    import pfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [63:0]          s_tdata,   // error, feedforward
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [31:0]          m_tdata,   // drive
    input  logic                 m_tuser,   // saturated
    output int                   mismatches,
    output int                   pending
);

    localparam longint ALPHA_FULL  = 1 << ALPHA_BITS;
    localparam longint FILT_SPAN   = 64'sd1 << DATA_WIDTH_DEF;
    localparam longint LIMIT_RESET = (64'sd1 << (DATA_WIDTH_DEF - 1)) - 1;

    typedef struct packed {
        logic [31:0] drive;
        logic        saturated;
    } drive_result_t;

    drive_result_t expected_drives[$];

    // Register copy
    longint kp_gain, ki_dt_gain, kd_gain, ff_gain;
    longint alpha, int_limit, out_limit;
    logic   cond_integration;

    // Controller state
    longint prev_error, integral, filt_diff;

    // Exact product, floored by the shift, saturated to the term limit
    function automatic longint gain_product(input longint a, input longint b, input int shift);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] wide;
        wa = 128'(a);
        wb = 128'(b);
        wide = (wa * wb) >>> shift;
        if (wide > TERM_LIM)
            return TERM_LIM;
        if (wide < -TERM_LIM)
            return -TERM_LIM;
        return wide[63:0];
    endfunction

    function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the controller by one sample and return the drive it produces
    function automatic drive_result_t next_drive(input logic [31:0] err_bits,
                                                 input logic [31:0] ffin_bits);
        longint err, ffin, p_term, ff_term, i_term, d_term;
        longint inc, tent, weight, step, total, drive_val;
        logic hold_integral;
        drive_result_t res;
        err = longint'($signed(err_bits));
        ffin = longint'($signed(ffin_bits));
        p_term = gain_product(kp_gain, err, FRAC_BITS_DEF);
        ff_term = gain_product(ffin, ff_gain, FRAC_BITS_DEF);
        i_term = 0;
        d_term = 0;

        // Integrate, unless conditional mode sees the output already pushed into the limit
        if (ki_dt_gain != 0)
        begin
            inc = gain_product(ki_dt_gain, err, FRAC_BITS_DEF);
            hold_integral = 1'b0;
            if (cond_integration)
            begin
                tent = p_term + integral + inc
                     + gain_product(kd_gain, filt_diff, FRAC_BITS_DEF) + ff_term;
                hold_integral = (tent >= out_limit && err > 0)
                             || (tent <= -out_limit && err < 0);
            end
            if (!hold_integral)
                integral = clamp_range(integral + inc, -int_limit, int_limit);
            i_term = integral;
        end

        // Low-pass the error difference; weights above one act as one
        if (kd_gain != 0)
        begin
            weight = (alpha > ALPHA_FULL) ? ALPHA_FULL : alpha;
            step = gain_product(weight, err - prev_error - filt_diff, ALPHA_BITS);
            filt_diff = clamp_range(filt_diff + step, -FILT_SPAN, FILT_SPAN - 1);
            d_term = gain_product(kd_gain, filt_diff, FRAC_BITS_DEF);
        end

        // Clamp the sum; landing exactly on the limit is not saturation
        total = p_term + i_term + d_term + ff_term;
        drive_val = total;
        res.saturated = 1'b0;
        if (total > out_limit)
        begin
            drive_val = out_limit;
            res.saturated = 1'b1;
        end
        else if (total < -out_limit)
        begin
            drive_val = -out_limit;
            res.saturated = 1'b1;
        end
        res.drive = drive_val[31:0];
        prev_error = err;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        drive_result_t want;
        if (!rst_n)
        begin
            kp_gain = 0;
            ki_dt_gain = 0;
            kd_gain = 0;
            ff_gain = 0;
            alpha = ALPHA_FULL;
            int_limit = LIMIT_RESET;
            out_limit = LIMIT_RESET;
            cond_integration = 1'b0;
            prev_error = 0;
            integral = 0;
            filt_diff = 0;
            expected_drives.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            // Track register writes
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_KP:         kp_gain = longint'($signed(cfg_wdata));
                    REG_KI_DT:      ki_dt_gain = longint'($signed(cfg_wdata));
                    REG_KD_OVER_DT: kd_gain = longint'($signed(cfg_wdata));
                    REG_ALPHA:      alpha = longint'(cfg_wdata[ALPHA_W-1:0]);
                    REG_INT_LIMIT:  int_limit = longint'(cfg_wdata[30:0]);
                    REG_OUT_LIMIT:  out_limit = longint'(cfg_wdata[30:0]);
                    REG_FF_GAIN:    ff_gain = longint'($signed(cfg_wdata));
                    REG_AW_MODE:    cond_integration = cfg_wdata[0];
                    default:        ;
                endcase
            end

            // Predict on every accepted sample
            if (s_tvalid && s_tready)
                expected_drives.push_back(next_drive(s_tdata[31:0], s_tdata[63:32]));

            // Compare every accepted result against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (expected_drives.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected drive transaction: drive %0d saturated %0b",
                                 $signed(m_tdata), m_tuser);
                end
                else
                begin
                    want = expected_drives.pop_front();
                    if (m_tdata !== want.drive || m_tuser !== want.saturated)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("drive mismatch: expected %0d sat %0b, got %0d sat %0b",
                                     $signed(want.drive), want.saturated,
                                     $signed(m_tdata), m_tuser);
                    end
                end
            end
            pending = expected_drives.size();
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench
    import pfd_pkg::*;
();

    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 250;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata = '0;    // error, feedforward
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;         // drive
    logic                 m_tuser;         // saturated

    int          drive_mismatches;
    int          drives_pending;
    bit          send_eager = 1'b0;
    bit          take_eager = 1'b0;
    int          taken = 0;
    logic [31:0] last_error = '0;

    pid_filtered_derivative_antiwindup_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    drive_checker drive_watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (drive_mismatches),
        .pending    (drives_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
    endtask

    task automatic configure(input logic [31:0] kp, input logic [31:0] ki_dt,
                             input logic [31:0] kd_over_dt, input logic [31:0] alpha,
                             input logic [31:0] int_limit, input logic [31:0] out_limit,
                             input logic [31:0] ff_gain, input logic [31:0] aw_mode);
        write_reg(REG_KP, kp);
        write_reg(REG_KI_DT, ki_dt);
        write_reg(REG_KD_OVER_DT, kd_over_dt);
        write_reg(REG_ALPHA, alpha);
        write_reg(REG_INT_LIMIT, int_limit);
        write_reg(REG_OUT_LIMIT, out_limit);
        write_reg(REG_FF_GAIN, ff_gain);
        write_reg(REG_AW_MODE, aw_mode);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one sample after a random gap and hold it until the core takes it
    task automatic send_sample(input logic [31:0] err, input logic [31:0] ffin);
        int gap;
        if ($urandom_range(0, 63) == 0)
            send_eager = !send_eager;
        gap = send_eager ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata <= {ffin, err};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        last_error = err;
    endtask

    // Drop valid and wait for every predicted drive to come back
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (drives_pending == 0);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_gain();
        logic [31:0] mag;
        mag = $urandom_range(0, 32'h3_FFFF);
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'h0001_0000;
            2:       return $urandom();
            3:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 1) ? mag : -mag;
        endcase
    endfunction

    // Limits carry a random top bit that the register must drop
    function automatic logic [31:0] pick_limit();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = 32'h7FFF_FFFF;
            1:       v = $urandom();
            2:       v = 32'h0;
            default: v = $urandom_range(0, 32'h20_0000);
        endcase
        v[31] = 1'($urandom_range(0, 1));
        return v;
    endfunction

    function automatic logic [31:0] pick_alpha();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 3))
            0:       v[16:0] = 17'h0;
            1:       v[16:0] = ALPHA_ONE;
            2:       v[16:0] = 17'($urandom_range(0, 65536));
            default: v[16:0] = 17'($urandom_range(65537, 131071));
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_error();
        logic [31:0] mag;
        mag = $urandom_range(0, 32'h4_0000);
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? mag : -mag;
            2:
            begin
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0;
                    3:       return 32'h1;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            // keep the sign of the last error to wind the integral up
            default: return last_error[31] ? -mag : mag;
        endcase
    endfunction

    function automatic logic [31:0] pick_ff();
        logic [31:0] mag;
        mag = $urandom_range(0, 32'h8_0000);
        case ($urandom_range(0, 3))
            0:       return 32'h0;
            1:       return $urandom();
            default: return $urandom_range(0, 1) ? mag : -mag;
        endcase
    endfunction

    task automatic run_random_phase(input int count);
        repeat (count)
            send_sample(pick_error(), pick_ff());
    endtask

    // Result side: random stalls, two long hold-offs to back the core up
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                take_eager = !take_eager;
            gap = take_eager ? 0 : $urandom_range(0, 18);
            if (taken == 400 || taken == 1300)
                gap = HOLD_CYCLES;
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            taken++;
            @(negedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: every gain is zero
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        drain();

        // Field extremes, weight above one, conditional integration into the limit
        configure(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_FFFF,
                  32'h0003_0000, 32'h0005_0000, 32'h0001_0000, 32'h1);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'h0, 32'h0);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'h1, 32'h1);
        repeat (6) send_sample(32'h0002_0000, 32'h0);
        repeat (6) send_sample(32'hFFFE_0000, 32'h0);
        drain();

        // Sum landing exactly on the limit, then just past it
        configure(32'h0001_0000, 32'h0, 32'h0, 32'h0000_8000,
                  32'h0, 32'h0005_0000, 32'h0, 32'h0);
        send_sample(32'h0005_0000, 32'h0);
        send_sample(32'hFFFB_0000, 32'h0);
        send_sample(32'h0005_0001, 32'h0);
        drain();

        // Zero limits hold the integral and the drive at zero
        configure(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000,
                  32'h0, 32'h0, 32'h0001_0000, 32'h0);
        send_sample(32'h0001_0000, 32'h0001_0000);
        send_sample(32'hFFFF_0000, 32'h0);
        drain();

        // Random phases: the two register extremes first, then random settings
        for (int phase = 0; phase < 7; phase++)
        begin
            if (phase == 0)
                configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1);
            else if (phase == 1)
                configure(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFE);
            else
                configure(pick_gain(), pick_gain(), pick_gain(), pick_alpha(),
                          pick_limit(), pick_limit(), pick_gain(),
                          {31'($urandom()), 1'($urandom_range(0, 1))});
            run_random_phase(PHASE_ITEMS);
            drain();
        end

        repeat (20) @(negedge clk);
        if (drive_mismatches == 0 && drives_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
